// ===== rtl/core/rstu_pkg.sv =====
// Shared constants, status codes and the character-to-digit decoder of the
// radix string to 128-bit parser. No dependencies.

package rstu_pkg;

    localparam int unsigned MAX_CHARS = 65535;
    localparam int POS_W   = $clog2(64'(MAX_CHARS) + 64'd1);
    localparam int OFF_W   = 16;
    localparam int CHAR_W  = 8;
    localparam int RADIX_W = 6;
    localparam int ACC_W   = 128;
    localparam int HALF_W  = 64;
    localparam int STAT_W  = 2;
    localparam int PROD_W  = ACC_W + RADIX_W;
    localparam int OUT_W   = 2 * HALF_W + OFF_W + STAT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_ONE   = 6'd1;
    localparam logic [RADIX_W-1:0] RADIX_BIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] DIGIT_NONE  = 6'd36;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADRADIX = 2'd1,
        ST_NEG      = 2'd2,
        ST_OVF      = 2'd3
    } status_t;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UB    = 8'h42;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

    // Digit value of a character, DIGIT_NONE for anything that is no digit.
    function automatic logic [RADIX_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [RADIX_W-1:0] d;
        d = DIGIT_NONE;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            d = RADIX_W'(c - CH_ZERO);
        end else if (c inside {[CH_LA:CH_LZ]}) begin
            d = RADIX_W'(c - CH_LA + 8'd10);
        end else if (c inside {[CH_UA:CH_UZ]}) begin
            d = RADIX_W'(c - CH_UA + 8'd10);
        end
        return d;
    endfunction

endpackage

// ===== rtl/core/radix_string_to_u128_parser.sv =====
// Top level of the radix string to 128-bit unsigned parser.
// Depends on rstu_pkg for constants, status codes and the digit decoder.
//
// Usage:
//   s_* carries one character per transfer in s_tdata; a zero byte ends the
//   string. Each terminator yields exactly one transfer on m_*, every other
//   byte yields none. m_tdata holds, from the lowest bit up: value_high[63:0],
//   value_low[63:0], end_offset[15:0], parse_status[1:0], six zero bits.
//   cfg_* writes the radix (2..36, 0 for prefix auto-detect); write it only
//   while no string is in flight. It is sampled at the first byte of a string.
// Throughput and datapath:
//   One character per cycle while no terminator waits for a free result
//   register. A byte is captured in the input register and processed from
//   there by one 128 x 6 bit multiply-add that updates the accumulator; a
//   terminator loads the result register instead, which drives m_tvalid.
// Reset:
//   aresetn clears the parse state, empties both registers and sets the
//   radix to 10.
// Stalls:
//   While a result waits on m_tready, non-terminator bytes keep flowing; a
//   second terminator waits in the input register, and s_tready drops only
//   then.

module radix_string_to_u128_parser
    import rstu_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [RADIX_W-1:0]     cfg_data,      // radix
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [CHAR_W-1:0]      s_tdata,       // char_byte[7:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // value_high[63:0], value_low[127:64], end_offset[143:128],
    // parse_status[145:144], zero pad[151:146]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        PH_WS,
        PH_SIGN,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    logic [RADIX_W-1:0] radix_reg;
    logic               in_valid_reg;
    logic [CHAR_W-1:0]  in_char_reg;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;

    logic [ACC_W-1:0]   acc_reg,   acc_next;
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [POS_W-1:0]   stop_reg,  stop_next;
    phase_t             phase_reg, phase_next;
    logic [RADIX_W-1:0] eff_reg,   eff_next;
    status_t            err_reg,   err_next;
    logic [OUT_W-1:0]   out_data_next;

    logic               is_term;
    logic               out_free;
    logic               advance;
    logic               take;
    logic [RADIX_W-1:0] digit;
    logic [PROD_W-1:0]  prod;
    logic [POS_W-1:0]   off_pos;
    logic [ACC_W-1:0]   out_value;

    assign cfg_ready = 1'b1;
    assign is_term   = (in_char_reg == CH_NUL);
    assign out_free  = !out_valid_reg || m_tready;
    // Only a terminator needs room in the result register.
    assign advance   = in_valid_reg && (!is_term || out_free);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(OUT_TDATA_W - OUT_W)'(0), out_data_reg};

    assign digit = digit_of(in_char_reg);

    always_comb begin
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        stop_next  = stop_reg;
        phase_next = phase_reg;
        eff_next   = eff_reg;
        err_next   = err_reg;
        take       = 1'b0;
        prod       = '0;
        off_pos    = '0;
        out_value  = '0;

        // The radix is sampled at the first byte of a string.
        if (pos_reg == '0 && phase_reg == PH_WS) begin
            eff_next = radix_reg;
            if (radix_reg == RADIX_ONE || radix_reg > RADIX_MAX) begin
                err_next   = ST_BADRADIX;
                stop_next  = '0;
                phase_next = PH_DONE;
            end
        end

        off_pos = (phase_next == PH_DONE) ? stop_next : pos_reg;
        case (err_next)
            ST_OVF:  out_value = '1;
            ST_OK:   out_value = acc_reg;
            default: out_value = '0;
        endcase
        out_data_next = {err_next, off_pos[OFF_W-1:0],
                         out_value[HALF_W-1:0], out_value[ACC_W-1:HALF_W]};

        if (is_term) begin
            acc_next   = '0;
            pos_next   = '0;
            stop_next  = '0;
            phase_next = PH_WS;
            eff_next   = '0;
            err_next   = ST_OK;
        end else begin
            case (phase_next)
                PH_WS: begin
                    if (in_char_reg == CH_SPACE || in_char_reg inside {[CH_TAB:CH_CR]}) begin
                        phase_next = PH_WS;
                    end else if (in_char_reg == CH_PLUS) begin
                        phase_next = PH_SIGN;
                    end else if (in_char_reg == CH_MINUS) begin
                        err_next   = ST_NEG;
                        stop_next  = pos_reg;
                        phase_next = PH_DONE;
                    end else if (in_char_reg == CH_ZERO && (eff_next == RADIX_AUTO ||
                                 eff_next == RADIX_BIN || eff_next == RADIX_HEX)) begin
                        phase_next = PH_ZERO;
                    end else begin
                        if (eff_next == RADIX_AUTO) begin
                            eff_next = RADIX_DEC;
                        end
                        take = 1'b1;
                    end
                end
                PH_SIGN: begin
                    if (in_char_reg == CH_ZERO && (eff_next == RADIX_AUTO ||
                        eff_next == RADIX_BIN || eff_next == RADIX_HEX)) begin
                        phase_next = PH_ZERO;
                    end else begin
                        if (eff_next == RADIX_AUTO) begin
                            eff_next = RADIX_DEC;
                        end
                        take = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if ((in_char_reg == CH_LX || in_char_reg == CH_UX) &&
                        (eff_next == RADIX_AUTO || eff_next == RADIX_HEX)) begin
                        eff_next   = RADIX_HEX;
                        phase_next = PH_DIGITS;
                    end else if ((in_char_reg == CH_LB || in_char_reg == CH_UB) &&
                                 (eff_next == RADIX_AUTO || eff_next == RADIX_BIN)) begin
                        eff_next   = RADIX_BIN;
                        phase_next = PH_DIGITS;
                    end else begin
                        if (eff_next == RADIX_AUTO) begin
                            eff_next = RADIX_OCT;
                        end
                        take = 1'b1;
                    end
                end
                PH_DIGITS: take = 1'b1;
                default:   take = 1'b0;
            endcase

            if (take) begin
                prod = {{RADIX_W{1'b0}}, acc_reg} * PROD_W'(eff_next) + PROD_W'(digit);
                if (digit >= eff_next) begin
                    stop_next  = pos_reg;
                    phase_next = PH_DONE;
                end else if (|prod[PROD_W-1:ACC_W]) begin
                    err_next   = ST_OVF;
                    stop_next  = pos_reg;
                    phase_next = PH_DONE;
                end else begin
                    acc_next   = prod[ACC_W-1:0];
                    phase_next = PH_DIGITS;
                end
            end

            if (pos_reg != POS_W'(MAX_CHARS)) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg     <= RADIX_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            pos_reg       <= '0;
            stop_reg      <= '0;
            phase_reg     <= PH_WS;
            eff_reg       <= '0;
            err_reg       <= ST_OK;
        end else begin
            if (cfg_valid && cfg_ready) begin
                radix_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_char_reg  <= s_tdata;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance && is_term) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= out_data_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                acc_reg   <= acc_next;
                pos_reg   <= pos_next;
                stop_reg  <= stop_next;
                phase_reg <= phase_next;
                eff_reg   <= eff_next;
                err_reg   <= err_next;
            end
        end
    end

    // An invalid radix reports zero value and zero offset.
    a_badradix_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[145:144] == ST_BADRADIX |-> m_tdata[143:0] == '0)
        else $error("invalid radix result carries a nonzero value or offset");

    // Overflow saturates the value to all ones.
    a_ovf_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[145:144] == ST_OVF |-> m_tdata[127:0] == '1)
        else $error("overflow result is not all ones");

    // A processed terminator always lands in the result register.
    a_term_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_term |=> out_valid_reg && pos_reg == '0 && phase_reg == PH_WS)
        else $error("terminator did not produce a result and rearm");

    // The position saturates and only returns to zero for a new string.
    a_pos_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg == POS_W'(MAX_CHARS) |=> pos_reg == POS_W'(MAX_CHARS) || pos_reg == '0)
        else $error("character position wrapped");

endmodule
